/* rtl/core/buddy_block_allocator_top_defines.svh */
// Assertion macros for the buddy block allocator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("buddy allocator check failed");

// Next-cycle implication, disabled during reset.
`define BBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("buddy allocator check failed");

`endif

/* rtl/core/bba_pkg.sv */
// Shared types and codes for the buddy block allocator.
// No dependencies.
`default_nettype none
package bba_pkg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_WT,
        S_TAKE,
        S_SPLIT,
        S_ANC_RD,
        S_ANC_WT,
        S_MRG_RD,
        S_MRG_WT,
        S_MARK,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BAD     = 2'd2
    } status_t;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

endpackage
`default_nettype wire

/* rtl/core/bba_mem.sv */
// Single-port bitmap memory with registered read data.
// Used by buddy_block_allocator_top; no package dependencies.
`default_nettype none
module bba_mem #(
    parameter int AW = 11
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic          wdata,
    output logic               rdata
);

    logic mem [0:(1 << AW) - 1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/buddy_block_allocator_top.sv */
// Top level of the buddy block allocator: request sequencer and result register.
// Depends on bba_pkg, bba_mem and buddy_block_allocator_top_defines.svh.
//
// Buddy allocator over 2^POOL_ORDER minimum blocks. The free state is one bit per
// aligned block of every order, kept in heap order (root at index 1) in a single-port
// bitmap RAM, and one sequencer walks it one bit per step. A request is one input
// transaction (tuser selects allocate or free) and yields exactly one result
// transaction. Timing is set by the RAM port: a bitmap read presents the address and
// then uses the registered data, and a write needs no wait state. An allocate scans
// the bits from the first block of the needed order onward in address order and order
// by order (below 2^(POOL_ORDER+1)), takes the first free block and splits it down to
// the needed order. A free reads the block and its ancestors up to the root, then
// merges it with free buddies order by order and marks the merged block free; a
// double free answers once one of those reads finds a free block. Errors caught by the
// range checks answer straight from the decode step. A finished result may wait for
// the output register to empty. After reset a clearing pass writes all 2^(POOL_ORDER+1)
// bitmap bits (only the whole pool free) and no request is taken meanwhile. One
// request is worked at a time; the result is copied into an output register, so the
// next request is accepted once the sequencer is idle again, even while the previous
// result still waits downstream.
`default_nettype none
`include "buddy_block_allocator_top_defines.svh"
module buddy_block_allocator_top #(
    parameter int POOL_ORDER = 10
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // func (1 bit)
    input  wire logic s_tuser,
    // req_size (POOL_ORDER+1 bits), free_addr (POOL_ORDER bits), zero pad
    input  wire logic [((2 * POOL_ORDER + 1 + 7) / 8) * 8 - 1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // status (2 bits), block_addr (POOL_ORDER bits), block_order, zero pad
    output logic [((2 + POOL_ORDER + $clog2(POOL_ORDER + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int SW     = POOL_ORDER + 1;          // size width
    localparam int PW     = POOL_ORDER;              // address width
    localparam int OW     = $clog2(POOL_ORDER + 1);  // order width
    localparam int IW     = POOL_ORDER + 1;          // bitmap index width
    localparam int OUT_TW = ((2 + PW + OW + 7) / 8) * 8;

    bba_pkg::state_t  state_reg, state_next;
    logic             func_reg, func_next;
    logic [SW-1:0]    size_reg, size_next;
    logic [PW-1:0]    addr_reg, addr_next;
    logic [OW-1:0]    need_reg, need_next;
    logic [OW-1:0]    k_reg, k_next;
    logic [PW-1:0]    p_reg, p_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    base_reg, base_next;
    logic [IW-1:0]    clr_reg, clr_next;
    bba_pkg::status_t res_st_reg, res_st_next;
    logic [PW-1:0]    res_addr_reg, res_addr_next;
    logic [OW-1:0]    res_ord_reg, res_ord_next;
    bba_pkg::status_t out_st_reg, out_st_next;
    logic [PW-1:0]    out_addr_reg, out_addr_next;
    logic [OW-1:0]    out_ord_reg, out_ord_next;
    logic             m_valid_reg, m_valid_next;

    logic          mem_en, mem_we, mem_wdata, mem_rdata;
    logic [IW-1:0] mem_addr;

    logic [OW-1:0] ord;
    logic          size_zero, size_over, misalign, out_pool;
    logic [IW-1:0] scan_off;

    // Heap index of the block of order k at position p.
    function automatic logic [IW-1:0] node(input logic [OW-1:0] k, input logic [PW-1:0] p);
        logic [IW-1:0] top;
        top = IW'(1) << (OW'(POOL_ORDER) - k);
        return top + IW'(p);
    endfunction

    bba_mem #(
        .AW (IW)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Round the size up to an order; independent compares per order.
    always_comb
    begin
        ord = OW'(POOL_ORDER);
        for (int k = POOL_ORDER - 1; k >= 0; k--)
        begin
            if (size_reg <= (SW'(1) << k))
            begin
                ord = OW'(k);
            end
        end
    end

    assign size_zero = (size_reg == '0);
    assign size_over = size_reg[SW-1] && (size_reg[SW-2:0] != '0);
    assign misalign  = ((addr_reg & ((PW'(1) << ord) - PW'(1))) != '0);
    assign out_pool  = ((SW'(addr_reg) + (SW'(1) << ord)) > (SW'(1) << POOL_ORDER));
    assign scan_off  = idx_reg - base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bba_pkg::S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working registers need no reset.
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        size_reg     <= size_next;
        addr_reg     <= addr_next;
        need_reg     <= need_next;
        k_reg        <= k_next;
        p_reg        <= p_next;
        idx_reg      <= idx_next;
        base_reg     <= base_next;
        res_st_reg   <= res_st_next;
        res_addr_reg <= res_addr_next;
        res_ord_reg  <= res_ord_next;
        out_st_reg   <= out_st_next;
        out_addr_reg <= out_addr_next;
        out_ord_reg  <= out_ord_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        size_next     = size_reg;
        addr_next     = addr_reg;
        need_next     = need_reg;
        k_next        = k_reg;
        p_next        = p_reg;
        idx_next      = idx_reg;
        base_next     = base_reg;
        clr_next      = clr_reg;
        res_st_next   = res_st_reg;
        res_addr_next = res_addr_reg;
        res_ord_next  = res_ord_reg;
        out_st_next   = out_st_reg;
        out_addr_next = out_addr_reg;
        out_ord_next  = out_ord_reg;
        m_valid_next  = m_valid_reg;
        mem_en        = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = '0;
        mem_wdata     = 1'b0;
        s_tready      = 1'b0;

        // Drop the result valid once the downstream side takes it.
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            bba_pkg::S_CLEAR:
            begin
                // Sweep the bitmap: only the root block (index 1) free.
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = (clr_reg == IW'(1));
                clr_next  = clr_reg + IW'(1);
                if (clr_reg == '1)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    func_next  = s_tuser;
                    size_next  = s_tdata[SW-1:0];
                    addr_next  = s_tdata[SW+PW-1:SW];
                    state_next = bba_pkg::S_DECODE;
                end
            end
            bba_pkg::S_DECODE:
            begin
                res_addr_next = '0;
                res_ord_next  = '0;
                need_next     = ord;
                k_next        = ord;
                if (size_zero)
                begin
                    res_st_next = bba_pkg::ST_BAD;
                    state_next  = bba_pkg::S_RESP;
                end
                else if (func_reg == bba_pkg::FUNC_ALLOC)
                begin
                    if (size_over)
                    begin
                        res_st_next = bba_pkg::ST_NOSPACE;
                        state_next  = bba_pkg::S_RESP;
                    end
                    else
                    begin
                        base_next  = node(ord, '0);
                        idx_next   = node(ord, '0);
                        state_next = bba_pkg::S_SCAN_RD;
                    end
                end
                else
                begin
                    if (size_over || misalign || out_pool)
                    begin
                        res_st_next = bba_pkg::ST_BAD;
                        state_next  = bba_pkg::S_RESP;
                    end
                    else
                    begin
                        p_next     = addr_reg >> ord;
                        state_next = bba_pkg::S_ANC_RD;
                    end
                end
            end
            bba_pkg::S_SCAN_RD:
            begin
                mem_en     = 1'b1;
                mem_addr   = idx_reg;
                state_next = bba_pkg::S_SCAN_WT;
            end
            bba_pkg::S_SCAN_WT:
            begin
                if (mem_rdata)
                begin
                    p_next     = scan_off[PW-1:0];
                    state_next = bba_pkg::S_TAKE;
                end
                else if (scan_off == base_reg - IW'(1))
                begin
                    // End of this order: move up one order or give up at the root.
                    if (base_reg == IW'(1))
                    begin
                        res_st_next = bba_pkg::ST_NOSPACE;
                        state_next  = bba_pkg::S_RESP;
                    end
                    else
                    begin
                        base_next  = base_reg >> 1;
                        idx_next   = base_reg >> 1;
                        k_next     = k_reg + OW'(1);
                        state_next = bba_pkg::S_SCAN_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = bba_pkg::S_SCAN_RD;
                end
            end
            bba_pkg::S_TAKE:
            begin
                mem_en     = 1'b1;
                mem_we     = 1'b1;
                mem_addr   = node(k_reg, p_reg);
                mem_wdata  = 1'b0;
                state_next = bba_pkg::S_SPLIT;
            end
            bba_pkg::S_SPLIT:
            begin
                if (k_reg == need_reg)
                begin
                    res_st_next   = bba_pkg::ST_OK;
                    res_addr_next = p_reg << need_reg;
                    res_ord_next  = need_reg;
                    state_next    = bba_pkg::S_RESP;
                end
                else
                begin
                    // Split: hand back the upper half one order down.
                    mem_en    = 1'b1;
                    mem_we    = 1'b1;
                    mem_addr  = node(k_reg - OW'(1), (p_reg << 1) | PW'(1));
                    mem_wdata = 1'b1;
                    k_next    = k_reg - OW'(1);
                    p_next    = p_reg << 1;
                end
            end
            bba_pkg::S_ANC_RD:
            begin
                mem_en     = 1'b1;
                mem_addr   = node(k_reg, p_reg);
                state_next = bba_pkg::S_ANC_WT;
            end
            bba_pkg::S_ANC_WT:
            begin
                if (mem_rdata)
                begin
                    res_st_next = bba_pkg::ST_BAD;
                    state_next  = bba_pkg::S_RESP;
                end
                else if (k_reg == OW'(POOL_ORDER))
                begin
                    k_next     = need_reg;
                    p_next     = addr_reg >> need_reg;
                    state_next = bba_pkg::S_MRG_RD;
                end
                else
                begin
                    k_next     = k_reg + OW'(1);
                    p_next     = p_reg >> 1;
                    state_next = bba_pkg::S_ANC_RD;
                end
            end
            bba_pkg::S_MRG_RD:
            begin
                if (k_reg == OW'(POOL_ORDER))
                begin
                    state_next = bba_pkg::S_MARK;
                end
                else
                begin
                    mem_en     = 1'b1;
                    mem_addr   = node(k_reg, p_reg ^ PW'(1));
                    state_next = bba_pkg::S_MRG_WT;
                end
            end
            bba_pkg::S_MRG_WT:
            begin
                if (mem_rdata)
                begin
                    // Buddy is free: absorb it and climb one order.
                    mem_en     = 1'b1;
                    mem_we     = 1'b1;
                    mem_addr   = node(k_reg, p_reg ^ PW'(1));
                    mem_wdata  = 1'b0;
                    k_next     = k_reg + OW'(1);
                    p_next     = p_reg >> 1;
                    state_next = bba_pkg::S_MRG_RD;
                end
                else
                begin
                    state_next = bba_pkg::S_MARK;
                end
            end
            bba_pkg::S_MARK:
            begin
                mem_en        = 1'b1;
                mem_we        = 1'b1;
                mem_addr      = node(k_reg, p_reg);
                mem_wdata     = 1'b1;
                res_st_next   = bba_pkg::ST_OK;
                res_addr_next = addr_reg;
                res_ord_next  = need_reg;
                state_next    = bba_pkg::S_RESP;
            end
            bba_pkg::S_RESP:
            begin
                // Hold until the output register is free, then copy the result into it.
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    out_st_next   = res_st_reg;
                    out_addr_next = res_addr_reg;
                    out_ord_next  = res_ord_reg;
                    state_next    = bba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TW'({out_ord_reg, out_addr_reg, out_st_reg});

    `BBA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `BBA_ASSERT_IMP(a_error_zero_fields, clk, rst_n,
        m_valid_reg && (out_st_reg != bba_pkg::ST_OK),
        (out_addr_reg == '0) && (out_ord_reg == '0))
    `BBA_ASSERT_NXT(a_resp_posts, clk, rst_n,
        (state_reg == bba_pkg::S_RESP) && (!m_valid_reg || m_tready), m_tvalid)

endmodule
`default_nettype wire

/* tb/tb_buddy_block_allocator_top.sv */
// Self-checking testbench for the buddy block allocator top level.
// Depends on bba_pkg and buddy_block_allocator_top; drives requests, predicts results.
`default_nettype none
module tb_buddy_block_allocator_top;

    localparam int ORD      = 10;
    localparam int POOL     = 1 << ORD;
    localparam int NODES    = 2 * POOL;
    localparam int SDW      = ((2 * ORD + 1 + 7) / 8) * 8;
    localparam int MDW      = ((2 + ORD + $clog2(ORD + 1) + 7) / 8) * 8;
    localparam int N_RANDOM = 1000;
    // Worst search walks the whole bitmap; leave room.
    localparam int WDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES = 200;

    // Holds a bit-level copy of the free bitmap and the pending answers.
    class alloc_scoreboard;
        bit                  free_bit [NODES];
        bba_pkg::status_t    want_status [$];
        logic [9:0]          want_addr [$];
        logic [3:0]          want_order [$];
        int                  held_addr [$];
        int                  held_size [$];
        int                  errors;

        function new();
            foreach (free_bit[i]) free_bit[i] = 1'b0;
            free_bit[1] = 1'b1;
            errors = 0;
        endfunction

        function int heap_idx(int k, int p);
            return (1 << (ORD - k)) + p;
        endfunction

        function int size_order(int size);
            int k;
            k = 0;
            while (k < ORD && (1 << k) < size) k++;
            return k;
        endfunction

        function void push(bba_pkg::status_t st, int addr, int ord);
            want_status.push_back(st);
            want_addr.push_back(addr[9:0]);
            want_order.push_back(ord[3:0]);
        endfunction

        // Note one accepted request and work out its answer.
        function void note(logic fn, int size, int addr);
            int need, k, p, n, q, a;
            bit found;
            found = 0;
            p = 0;
            if (fn == bba_pkg::FUNC_ALLOC)
            begin
                if (size == 0)
                begin
                    push(bba_pkg::ST_BAD, 0, 0);
                    return;
                end
                if (size > POOL)
                begin
                    push(bba_pkg::ST_NOSPACE, 0, 0);
                    return;
                end
                need = size_order(size);
                for (k = need; k <= ORD; k++)
                begin
                    n = 1 << (ORD - k);
                    for (p = 0; p < n; p++)
                        if (free_bit[heap_idx(k, p)])
                        begin
                            found = 1;
                            break;
                        end
                    if (found) break;
                end
                if (!found)
                begin
                    push(bba_pkg::ST_NOSPACE, 0, 0);
                    return;
                end
                free_bit[heap_idx(k, p)] = 0;
                while (k > need)
                begin
                    k--;
                    p = p << 1;
                    free_bit[heap_idx(k, p + 1)] = 1;
                end
                push(bba_pkg::ST_OK, p << need, need);
                held_addr.push_back(p << need);
                held_size.push_back(size);
                return;
            end
            if (size == 0 || size > POOL)
            begin
                push(bba_pkg::ST_BAD, 0, 0);
                return;
            end
            need = size_order(size);
            if ((addr & ((1 << need) - 1)) != 0 || addr + (1 << need) > POOL)
            begin
                push(bba_pkg::ST_BAD, 0, 0);
                return;
            end
            p = addr >> need;
            // Reject when the block or any enclosing block is already free.
            q = p;
            for (a = need; a <= ORD; a++)
            begin
                if (free_bit[heap_idx(a, q)])
                begin
                    push(bba_pkg::ST_BAD, 0, 0);
                    return;
                end
                q = q >> 1;
            end
            k = need;
            while (k < ORD && free_bit[heap_idx(k, p ^ 1)])
            begin
                free_bit[heap_idx(k, p ^ 1)] = 0;
                p = p >> 1;
                k++;
            end
            free_bit[heap_idx(k, p)] = 1;
            push(bba_pkg::ST_OK, addr, need);
        endfunction

        function void check(logic [MDW-1:0] d);
            bba_pkg::status_t st;
            logic [9:0]       ad;
            logic [3:0]       od;
            if (want_status.size() == 0)
            begin
                $error("result 0x%0h arrived with nothing pending", d);
                errors++;
                return;
            end
            st = want_status.pop_front();
            ad = want_addr.pop_front();
            od = want_order.pop_front();
            if (d[1:0] !== st)
            begin
                $error("status: expected %0d, got %0d", st, d[1:0]);
                errors++;
            end
            if (d[11:2] !== ad)
            begin
                $error("block_addr: expected %0d, got %0d", ad, d[11:2]);
                errors++;
            end
            if (d[15:12] !== od)
            begin
                $error("block_order: expected %0d, got %0d", od, d[15:12]);
                errors++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic           s_tuser;
    logic [SDW-1:0] s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [MDW-1:0] m_tdata;

    alloc_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  recv_hold;
    int  quiet_cycles;

    buddy_block_allocator_top #(.POOL_ORDER(ORD)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver: random stalls, plus a long hold-off on request so that the
    // result register stays full and the input side backs up.
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            recv_hold <= recv_hold - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every result transaction; count cycles with no transaction at all.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check(m_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Offer one request after a random gap and hold it until accepted.
    task automatic send_req(logic fn, int size, int addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = fn;
        s_tdata  = '0;
        s_tdata[10:0]  = size[10:0];
        s_tdata[20:11] = addr[9:0];
        do @(posedge clk); while (!s_tready);
        sb.note(fn, size[10:0], addr[9:0]);
        @(negedge clk);
    endtask

    // Mostly well-formed traffic: allocations of small sizes and frees of
    // blocks handed out earlier, with some raw noise mixed in.
    task automatic random_item();
        int roll, idx, sz;
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            send_req($urandom_range(1), $urandom_range(2047), $urandom_range(1023));
        end
        else if (roll < 50 && sb.held_addr.size() > 0)
        begin
            idx = $urandom_range(sb.held_addr.size() - 1);
            sz  = sb.held_size[idx];
            // Any size that rounds to the same order frees the same block.
            if ($urandom_range(3) == 0)
                sz = 1 << sb.size_order(sz);
            send_req(bba_pkg::FUNC_FREE, sz, sb.held_addr[idx]);
            sb.held_addr.delete(idx);
            sb.held_size.delete(idx);
        end
        else
        begin
            if ($urandom_range(19) == 0)
                sz = $urandom_range(1024, 1);
            else
                sz = $urandom_range(64, 1);
            send_req(bba_pkg::FUNC_ALLOC, sz, $urandom_range(1023));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = bba_pkg::FUNC_ALLOC;
        s_tdata = '0;
        m_tready = 1'b0;
        recv_hold = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed: range errors, whole pool, double free, splits, merges.
        send_req(bba_pkg::FUNC_ALLOC, 0, 0);
        send_req(bba_pkg::FUNC_ALLOC, 1025, 0);
        send_req(bba_pkg::FUNC_ALLOC, 2047, 1023);
        send_req(bba_pkg::FUNC_FREE, 0, 0);
        send_req(bba_pkg::FUNC_FREE, 2047, 0);
        send_req(bba_pkg::FUNC_FREE, 1024, 0);
        send_req(bba_pkg::FUNC_ALLOC, 1024, 0);
        send_req(bba_pkg::FUNC_ALLOC, 1, 0);
        send_req(bba_pkg::FUNC_FREE, 1024, 0);
        send_req(bba_pkg::FUNC_FREE, 1024, 0);
        send_req(bba_pkg::FUNC_ALLOC, 1, 0);
        send_req(bba_pkg::FUNC_ALLOC, 3, 0);
        send_req(bba_pkg::FUNC_FREE, 4, 2);
        send_req(bba_pkg::FUNC_FREE, 1, 8);
        send_req(bba_pkg::FUNC_FREE, 1, 1023);
        // Free an 8-block that still holds free pieces; it merges anyway.
        send_req(bba_pkg::FUNC_FREE, 8, 0);
        send_req(bba_pkg::FUNC_ALLOC, 512, 0);
        send_req(bba_pkg::FUNC_ALLOC, 513, 0);
        send_req(bba_pkg::FUNC_FREE, 512, 0);
        send_req(bba_pkg::FUNC_FREE, 1, 0);
        send_req(bba_pkg::FUNC_FREE, 513, 512);
        sb.held_addr.delete();
        sb.held_size.delete();

        // Phase one: sender idles 37%, receiver 68%; hold the receiver off
        // for a long stretch early on while requests keep coming.
        send_idle_pct = 37;
        recv_idle_pct = 68;
        recv_hold = 400;
        repeat (N_RANDOM / 3) random_item();
        send_idle_pct = 68;
        recv_idle_pct = 37;
        repeat (N_RANDOM / 3) random_item();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (N_RANDOM - 2 * (N_RANDOM / 3)) random_item();
        s_tvalid = 1'b0;

        // Drain, then let the block settle.
        while (sb.want_status.size() > 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
